### sv/dhqa_pkg.sv
`default_nettype none
package dhqa_pkg;

	localparam logic [1:0] OP_WORD    = 2'd0;
	localparam logic [1:0] OP_BYTE    = 2'd1;
	localparam logic [1:0] OP_SUBMIT  = 2'd2;
	localparam logic [1:0] OP_RELEASE = 2'd3;

	localparam logic [2:0] ST_ABSORBED  = 3'd0;
	localparam logic [2:0] ST_ACCEPTED  = 3'd1;
	localparam logic [2:0] ST_PAUSED    = 3'd2;
	localparam logic [2:0] ST_INVALID   = 3'd3;
	localparam logic [2:0] ST_DUPLICATE = 3'd4;
	localparam logic [2:0] ST_FULL      = 3'd5;
	localparam logic [2:0] ST_RELEASED  = 3'd6;
	localparam logic [2:0] ST_UNDERFLOW = 3'd7;

	localparam logic [2:0] REG_PAUSED        = 3'd0;
	localparam logic [2:0] REG_SHUTTING_DOWN = 3'd1;
	localparam logic [2:0] REG_MAX_ITEMS     = 3'd2;
	localparam logic [2:0] REG_MAX_BYTES     = 3'd3;
	localparam logic [2:0] REG_HEADER_BYTES  = 3'd4;
	localparam logic [2:0] REG_DUP_WINDOW    = 3'd5;

	localparam logic [15:0] RST_MAX_ITEMS    = 16'd64;
	localparam logic [39:0] RST_MAX_BYTES    = 40'd67108864;
	localparam logic [11:0] RST_HEADER_BYTES = 12'd256;
	localparam logic [15:0] RST_DUP_WINDOW   = 16'd500;

	localparam logic [63:0] FNV_BASIS  = 64'hcbf29ce484222325;
	localparam logic [7:0]  TYPE_LIMIT = 8'd128;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [63:0] data_word;
		logic [31:0] payload_length;
		logic [7:0]  type_length;
		logic [63:0] now_ms;
		logic        time_valid;
		logic        delivered;
	} item_t;

	typedef struct packed {
		logic        paused;
		logic        shutting_down;
		logic [15:0] max_queue_items;
		logic [39:0] max_queue_bytes;
		logic [11:0] header_bytes;
		logic [15:0] dup_window_ms;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] hash_value;
		logic [15:0] queued_items;
		logic [39:0] queued_bytes;
		logic [63:0] delivered_bytes;
		logic [63:0] delivered_events;
	} res_t;

	// The FNV prime is 2^40 + 0x1b3, so the product is a sum of shifted copies.
	function automatic logic [63:0] fnv_mix(input logic [63:0] h, input logic [63:0] v);
		logic [63:0] x;
		x = h ^ v;
		return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

endpackage
`default_nettype wire

### sv/dhqa_hash.sv
`default_nettype none
module dhqa_hash (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  dhqa_pkg::item_t item,
	output logic [63:0]    hash_value
);
	import dhqa_pkg::*;

	logic [63:0] hash_q;

	always_comb begin
		case (item.opcode)
			OP_WORD: hash_value = fnv_mix(hash_q, item.data_word);
			OP_BYTE: hash_value = fnv_mix(hash_q, {56'd0, item.data_word[7:0]});
			default: hash_value = hash_q;
		endcase
	end

	// Every submit restarts the hash, whatever the outcome.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= FNV_BASIS;
		end else if (advance) begin
			case (item.opcode)
				OP_WORD, OP_BYTE: hash_q <= hash_value;
				OP_SUBMIT: hash_q <= FNV_BASIS;
				default: hash_q <= hash_q;
			endcase
		end
	end

endmodule
`default_nettype wire

### sv/dhqa_admit.sv
`default_nettype none
module dhqa_admit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  dhqa_pkg::item_t item,
	input  dhqa_pkg::cfg_t  cfg,
	input  logic [63:0]     hash_value,
	output dhqa_pkg::res_t  res
);
	import dhqa_pkg::*;

	logic [63:0] last_hash_q;
	logic [31:0] last_len_q;
	logic [63:0] last_time_q;
	logic        has_prev_q;
	logic [15:0] items_q;
	logic [39:0] bytes_q;
	logic [63:0] dlv_bytes_q;
	logic [63:0] dlv_events_q;

	logic [32:0] size;
	logic [39:0] size40;
	logic [63:0] elapsed;
	logic [39:0] used;
	logic [39:0] room;
	logic        dup;
	logic        full;
	logic        type_bad;
	logic        accept;
	logic [2:0]  status;
	logic [15:0] items_n;
	logic [39:0] bytes_n;
	logic [63:0] dlv_bytes_n;
	logic [63:0] dlv_events_n;

	always_comb begin
		size     = 33'(cfg.header_bytes) + 33'(item.payload_length);
		size40   = {7'd0, size};
		elapsed  = item.now_ms - last_time_q;
		dup      = has_prev_q && item.time_valid && (hash_value == last_hash_q) &&
			(item.payload_length == last_len_q) && (item.now_ms >= last_time_q) &&
			(elapsed < 64'(cfg.dup_window_ms));
		used     = (bytes_q < cfg.max_queue_bytes) ? bytes_q : cfg.max_queue_bytes;
		room     = cfg.max_queue_bytes - used;
		full     = cfg.shutting_down || (items_q >= cfg.max_queue_items) || (size40 > room);
		type_bad = (item.type_length == 8'd0) || (item.type_length >= TYPE_LIMIT);

		status       = ST_ABSORBED;
		accept       = 1'b0;
		items_n      = items_q;
		bytes_n      = bytes_q;
		dlv_bytes_n  = dlv_bytes_q;
		dlv_events_n = dlv_events_q;

		case (item.opcode)
			OP_SUBMIT: begin
				if (cfg.paused) begin
					status = ST_PAUSED;
				end else if (type_bad) begin
					status = ST_INVALID;
				end else if (dup) begin
					status = ST_DUPLICATE;
				end else if (full) begin
					status = ST_FULL;
				end else begin
					status  = ST_ACCEPTED;
					accept  = 1'b1;
					items_n = items_q + 16'd1;
					bytes_n = bytes_q + size40;
				end
			end
			OP_RELEASE: begin
				status = ST_RELEASED;
				if (items_q == 16'd0) begin
					status = ST_UNDERFLOW;
				end else begin
					items_n = items_q - 16'd1;
				end
				if (bytes_q < size40) begin
					bytes_n = '0;
					status  = ST_UNDERFLOW;
				end else begin
					bytes_n = bytes_q - size40;
				end
				if (item.delivered) begin
					dlv_bytes_n  = dlv_bytes_q + 64'(item.payload_length);
					dlv_events_n = dlv_events_q + 64'd1;
				end
			end
			default: begin
				status = ST_ABSORBED;
			end
		endcase

		res.status           = status;
		res.hash_value       = hash_value;
		res.queued_items     = items_n;
		res.queued_bytes     = bytes_n;
		res.delivered_bytes  = dlv_bytes_n;
		res.delivered_events = dlv_events_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_hash_q  <= '0;
			last_len_q   <= '0;
			last_time_q  <= '0;
			has_prev_q   <= 1'b0;
			items_q      <= '0;
			bytes_q      <= '0;
			dlv_bytes_q  <= '0;
			dlv_events_q <= '0;
		end else if (advance) begin
			items_q      <= items_n;
			bytes_q      <= bytes_n;
			dlv_bytes_q  <= dlv_bytes_n;
			dlv_events_q <= dlv_events_n;
			if (accept) begin
				last_hash_q <= hash_value;
				last_len_q  <= item.payload_length;
				has_prev_q  <= item.time_valid;
				if (item.time_valid) begin
					last_time_q <= item.now_ms;
				end
			end
		end
	end

endmodule
`default_nettype wire

### sv/dedup_hash_queue_admission_unit.sv
`default_nettype none
// Hashes event content and admits events into a bounded queue, one item per clock cycle
// while m_axis_tready keeps up. Each item passes from the input register through the
// hash and admission logic into the result register; the running hash and queue counters
// update with it, so the next item sees them at once and absorb, submit and release items
// may follow one another without gaps. The user must write configuration registers through
// cfg_we, cfg_addr and cfg_wdata while no item is in flight; the block does not enforce it.
module dedup_hash_queue_admission_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// data_word, payload_length, type_length, now_ms, time_valid, delivered, zero pad
	input  logic [175:0] s_axis_tdata,
	// opcode
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// status, hash_value, queued_items, queued_bytes, delivered_bytes,
	// delivered_events, zero pad
	output logic [255:0] m_axis_tdata,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_addr,
	input  logic [39:0]  cfg_wdata
);
	import dhqa_pkg::*;

	cfg_t  cfg_q;
	item_t item_in;
	item_t item_s1;
	logic  valid_s1;
	logic  out_free;
	logic  advance;
	logic [63:0] hash_value;
	res_t  res;
	res_t  res_q;
	logic  m_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.paused          <= 1'b0;
			cfg_q.shutting_down   <= 1'b0;
			cfg_q.max_queue_items <= RST_MAX_ITEMS;
			cfg_q.max_queue_bytes <= RST_MAX_BYTES;
			cfg_q.header_bytes    <= RST_HEADER_BYTES;
			cfg_q.dup_window_ms   <= RST_DUP_WINDOW;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_PAUSED:        cfg_q.paused          <= cfg_wdata[0];
				REG_SHUTTING_DOWN: cfg_q.shutting_down   <= cfg_wdata[0];
				REG_MAX_ITEMS:     cfg_q.max_queue_items <= cfg_wdata[15:0];
				REG_MAX_BYTES:     cfg_q.max_queue_bytes <= cfg_wdata;
				REG_HEADER_BYTES:  cfg_q.header_bytes    <= cfg_wdata[11:0];
				REG_DUP_WINDOW:    cfg_q.dup_window_ms   <= cfg_wdata[15:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		item_in.opcode         = s_axis_tuser;
		item_in.data_word      = s_axis_tdata[63:0];
		item_in.payload_length = s_axis_tdata[95:64];
		item_in.type_length    = s_axis_tdata[103:96];
		item_in.now_ms         = s_axis_tdata[167:104];
		item_in.time_valid     = s_axis_tdata[168];
		item_in.delivered      = s_axis_tdata[169];
	end

	assign out_free      = !m_valid_q || m_axis_tready;
	assign advance       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= item_in;
		end
	end

	dhqa_hash u_hash (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.item       (item_s1),
		.hash_value (hash_value)
	);

	dhqa_admit u_admit (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.item       (item_s1),
		.cfg        (cfg_q),
		.hash_value (hash_value),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= advance;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {5'd0, res_q.delivered_events, res_q.delivered_bytes,
		res_q.queued_bytes, res_q.queued_items, res_q.hash_value, res_q.status};

	// An accepted event never leaves the queue empty.
	a_accept_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && res_q.status == ST_ACCEPTED) |-> (res_q.queued_items != 16'd0))
		else $error("accepted event left the item count at zero");

	// Absorb items always report the absorbed status.
	a_absorb_status: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (item_s1.opcode == OP_WORD || item_s1.opcode == OP_BYTE))
		|=> (m_valid_q && res_q.status == ST_ABSORBED))
		else $error("absorb item did not report absorbed");

	// A held input item waits unchanged until the result register frees up.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(item_s1)))
		else $error("input stage lost or changed a waiting item");

endmodule
`default_nettype wire
